### rtl/rgb_gamma_clamp_core_macros.svh
// Assertion macros shared by the gamma clamp RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef RGB_GAMMA_CLAMP_CORE_MACROS_SVH
`define RGB_GAMMA_CLAMP_CORE_MACROS_SVH

// Check that cond_a implies cond_b in the same cycle.
`define RGC_ASSERT_IMPL(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |-> (cond_b)) else $error("assertion failed");

// Check that cond_a implies cond_b in the next cycle.
`define RGC_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |=> (cond_b)) else $error("assertion failed");

`endif

### rtl/rgc_pkg.sv
// Package for the gamma clamp core: config struct, register indexes,
// reset values, the exp2 root table and the lane latency. No dependencies.
package rgc_pkg;

    localparam int CHANNEL_WIDTH_DEF = 16;
    localparam int REG_W = 16;
    localparam int RATIO_W = 32;
    localparam int IG_W = 29;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W = 4;

    // register indexes
    localparam logic [1:0] REG_CLAMP = 2'd0;
    localparam logic [1:0] REG_SCALE_M = 2'd1;
    localparam logic [1:0] REG_SCALE_C = 2'd2;
    localparam logic [1:0] REG_GAMMA = 2'd3;

    localparam logic [REG_W-1:0] CLAMP_RST = 16'd256;
    localparam logic [REG_W-1:0] SCALE_RST = 16'd256;
    localparam logic [REG_W-1:0] GAMMA_RST = 16'd9011;
    localparam logic [RATIO_W-1:0] RATIO_RST = 32'd65536;
    localparam logic [IG_W-1:0] IG_RST = 29'd29789;

    typedef struct packed {
        logic [REG_W-1:0]   clamp;
        logic [RATIO_W-1:0] ratio_mc;
        logic [RATIO_W-1:0] ratio_cm;
        logic [IG_W-1:0]    inv_gamma;
    } t_cfg;

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] rem;
        res = '0;
        b = 64'(1) << 62;
        rem = v;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-n) in Q1.30, built by repeated square roots from 2.0
    function automatic logic [31:0] root_at(input int n);
        logic [63:0] t;
        t = 64'(1) << 31;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            if (j <= n) begin
                t = isqrt64(t << 30);
            end
        end
        return t[31:0];
    endfunction

    // count of registers in a lane, from the scaling register to the output register
    function automatic int lane_lat(input int w);
        return $clog2(w + RATIO_W) + 2 * FRAC_BITS + 4;
    endfunction

endpackage

### rtl/rgb_gamma_clamp_core.sv
// Gamma clamp core: one RGB pixel per clock while busy is low.
// Accepts a pixel whenever start is high and busy is low; each result
// appears on the output ports for one cycle with o_done high and cannot
// be stalled, so the receiver must take every word. Each lane holds
// sixteen squaring stages in its log2 unit and sixteen root stages in
// its exp2 unit. After any register write, busy stays high while a
// shared radix-2 divider works out m/c, c/m and 1/gamma; no pixel is
// taken then.
`include "rgb_gamma_clamp_core_macros.svh"
module rgb_gamma_clamp_core #(
    parameter int CHANNEL_WIDTH = rgc_pkg::CHANNEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [CHANNEL_WIDTH-1:0]    i_red_in,
    input  logic [CHANNEL_WIDTH-1:0]    i_green_in,
    input  logic [CHANNEL_WIDTH-1:0]    i_blue_in,
    output logic                        o_done,
    output logic [CHANNEL_WIDTH-1:0]    o_red_out,
    output logic [CHANNEL_WIDTH-1:0]    o_green_out,
    output logic [CHANNEL_WIDTH-1:0]    o_blue_out
);
    import rgc_pkg::*;

    localparam int LAT = lane_lat(CHANNEL_WIDTH);

    t_cfg                     cfg;
    logic                     acc;
    logic [LAT-1:0]           r_vp;
    logic [CHANNEL_WIDTH-1:0] lr, lg, lb;

    rgc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_busy  (busy)
    );

    assign acc = start && !busy;

    // track words in flight through the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[LAT-2:0], acc};
        end
    end

    rgc_lane #(.CHANNEL_WIDTH(CHANNEL_WIDTH)) u_lane_r (
        .i_clk (i_clk), .i_x (i_red_in), .i_cfg (cfg), .o_y (lr)
    );
    rgc_lane #(.CHANNEL_WIDTH(CHANNEL_WIDTH)) u_lane_g (
        .i_clk (i_clk), .i_x (i_green_in), .i_cfg (cfg), .o_y (lg)
    );
    rgc_lane #(.CHANNEL_WIDTH(CHANNEL_WIDTH)) u_lane_b (
        .i_clk (i_clk), .i_x (i_blue_in), .i_cfg (cfg), .o_y (lb)
    );

    rgc_merge #(.CHANNEL_WIDTH(CHANNEL_WIDTH)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vp[LAT-1]),
        .i_r     (lr),
        .i_g     (lg),
        .i_b     (lb),
        .o_done  (o_done),
        .o_r     (o_red_out),
        .o_g     (o_green_out),
        .o_b     (o_blue_out)
    );

    `RGC_ASSERT_IMPL(a_lat, i_clk, i_rst_n, acc, ##(LAT + 1) o_done)
    `RGC_ASSERT_IMPL(a_busy_block, i_clk, i_rst_n, busy, !acc)
    `RGC_ASSERT_NEXT(a_vld_done, i_clk, i_rst_n, r_vp[LAT-1], o_done)

endmodule

### rtl/rgc_cfg.sv
// APB register file and shared ratio divider for the gamma clamp core.
// Depends on rgc_pkg and the assertion macro header.
`include "rgb_gamma_clamp_core_macros.svh"
module rgc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rgc_pkg::t_cfg               o_cfg,
    output logic                        o_busy
);
    import rgc_pkg::*;

    localparam logic [1:0] DIV_MC = 2'd0;
    localparam logic [1:0] DIV_CM = 2'd1;
    localparam logic [1:0] DIV_IG = 2'd2;

    logic [REG_W-1:0]   r_clamp, r_m, r_c, r_g;
    logic [RATIO_W-1:0] r_mc, r_cm;
    logic [IG_W-1:0]    r_ig;
    logic               r_busy, r_load;
    logic [1:0]         r_sel;
    logic [4:0]         r_cnt;
    logic [15:0]        r_rem, r_dvs;
    logic [31:0]        r_quo;

    logic               wr;
    logic [1:0]         idx;
    logic [REG_W-1:0]   m_eff, c_eff, g_eff;
    logic [16:0]        step;
    logic               n_bit;
    logic [15:0]        n_rem;
    logic [31:0]        n_quo;

    assign wr = psel && penable && pwrite;
    assign idx = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    // zero scale or gamma acts as one
    assign m_eff = (r_m == '0) ? 16'd1 : r_m;
    assign c_eff = (r_c == '0) ? 16'd1 : r_c;
    assign g_eff = (r_g == '0) ? 16'd1 : r_g;

    // one restoring step
    assign step = {r_rem, r_quo[31]};
    assign n_bit = (step >= {1'b0, r_dvs});
    assign n_rem = n_bit ? 16'(step - {1'b0, r_dvs}) : step[15:0];
    assign n_quo = {r_quo[30:0], n_bit};

    // hold registers, restart the ratio sweep on every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= CLAMP_RST;
            r_m <= SCALE_RST;
            r_c <= SCALE_RST;
            r_g <= GAMMA_RST;
            r_mc <= RATIO_RST;
            r_cm <= RATIO_RST;
            r_ig <= IG_RST;
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_sel <= DIV_MC;
            r_cnt <= '0;
        end else if (wr) begin
            case (idx)
                REG_CLAMP:   r_clamp <= pwdata[REG_W-1:0];
                REG_SCALE_M: r_m <= pwdata[REG_W-1:0];
                REG_SCALE_C: r_c <= pwdata[REG_W-1:0];
                REG_GAMMA:   r_g <= pwdata[REG_W-1:0];
                default: ;
            endcase
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_sel <= DIV_MC;
            r_cnt <= '0;
        end else if (r_busy && r_load) begin
            r_load <= 1'b0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                case (r_sel)
                    DIV_MC: r_mc <= n_quo;
                    DIV_CM: r_cm <= n_quo;
                    default: r_ig <= n_quo[IG_W-1:0];
                endcase
                if (r_sel == DIV_IG) begin
                    r_busy <= 1'b0;
                end else begin
                    r_sel <= r_sel + 2'd1;
                    r_load <= 1'b1;
                end
            end
        end
    end

    // load operands or advance the divider datapath
    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_rem <= '0;
            case (r_sel)
                DIV_MC: begin
                    r_quo <= {m_eff, 16'd0};
                    r_dvs <= c_eff;
                end
                DIV_CM: begin
                    r_quo <= {c_eff, 16'd0};
                    r_dvs <= m_eff;
                end
                default: begin
                    r_quo <= 32'd1 << 28;
                    r_dvs <= g_eff;
                end
            endcase
        end else begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_CLAMP:   prdata = 32'(r_clamp);
            REG_SCALE_M: prdata = 32'(r_m);
            REG_SCALE_C: prdata = 32'(r_c);
            REG_GAMMA:   prdata = 32'(r_g);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.clamp = r_clamp;
    assign o_cfg.ratio_mc = r_mc;
    assign o_cfg.ratio_cm = r_cm;
    assign o_cfg.inv_gamma = r_ig;
    assign o_busy = r_busy;

    `RGC_ASSERT_NEXT(a_wr_busy, i_clk, i_rst_n, wr, r_busy)
    `RGC_ASSERT_IMPL(a_cm_hold, i_clk, i_rst_n, !r_busy && $past(!r_busy), $stable(r_cm))
    `RGC_ASSERT_IMPL(a_mc_hold, i_clk, i_rst_n, !r_busy && $past(!r_busy), $stable(r_mc))

endmodule

### rtl/rgc_lane.sv
// One channel of the gamma curve: clamp, scale, normalize, log2, exp2, rescale.
// Depends on rgc_pkg.
module rgc_lane #(
    parameter int CHANNEL_WIDTH = rgc_pkg::CHANNEL_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic [CHANNEL_WIDTH-1:0] i_x,
    input  rgc_pkg::t_cfg            i_cfg,
    output logic [CHANNEL_WIDTH-1:0] o_y
);
    import rgc_pkg::*;

    localparam int W = CHANNEL_WIDTH;
    localparam int SW = W + RATIO_W;
    localparam int NS = $clog2(SW);
    localparam int NW = 1 << NS;
    localparam int OVL = NS + 2 * FRAC_BITS + 3;
    localparam logic [6:0] PTOP = 7'(SW - 1);
    localparam logic [W-1:0] MASK = '1;

    // bypass flag and value for clamped or zero words
    logic         r_ov [0:OVL-1];
    logic [W-1:0] r_ovv [0:OVL-1];

    logic [SW-1:0] r_s;
    logic [31:0]   clamp32;
    logic          ge;

    assign clamp32 = 32'(i_cfg.clamp);
    assign ge = (32'(i_x) >= clamp32);

    // scale the input and mark bypass cases
    always_ff @(posedge i_clk) begin
        r_s <= SW'(i_x) * SW'(i_cfg.ratio_mc);
        r_ov[0] <= ge || (i_x == '0);
        r_ovv[0] <= ge ? clamp32[W-1:0] : '0;
    end

    genvar gi;
    generate
        for (gi = 1; gi < OVL; gi++) begin : g_ov
            always_ff @(posedge i_clk) begin
                r_ov[gi] <= r_ov[gi-1];
                r_ovv[gi] <= r_ovv[gi-1];
            end
        end
    endgenerate

    // normalize: strip leading zeros one power of two per stage
    logic [NW-1:0] r_nv [0:NS];
    logic [NS-1:0] r_lz [0:NS];

    assign r_nv[0] = NW'(r_s) << (NW - SW);
    assign r_lz[0] = '0;

    generate
        for (gi = 0; gi < NS; gi++) begin : g_norm
            localparam int AMT = 1 << (NS - 1 - gi);
            logic zero;
            assign zero = (r_nv[gi][NW-1 -: AMT] == '0);
            always_ff @(posedge i_clk) begin
                r_nv[gi+1] <= zero ? (r_nv[gi] << AMT) : r_nv[gi];
                r_lz[gi+1] <= r_lz[gi] | (zero ? NS'(AMT) : '0);
            end
        end
    endgenerate

    // log2 fraction by repeated squaring, one bit per stage
    logic [31:0]          r_y [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fr [0:FRAC_BITS];
    logic [6:0]           r_p [0:FRAC_BITS];

    assign r_y[0] = {1'b0, r_nv[NS][NW-1 -: 31]};
    assign r_fr[0] = '0;
    assign r_p[0] = PTOP - 7'(r_lz[NS]);

    generate
        for (gi = 0; gi < FRAC_BITS; gi++) begin : g_log
            logic [63:0] sq;
            logic [33:0] t;
            assign sq = 64'(r_y[gi]) * 64'(r_y[gi]);
            assign t = sq[63:30];
            always_ff @(posedge i_clk) begin
                r_y[gi+1] <= t[31] ? t[32:1] : t[31:0];
                r_fr[gi+1] <= r_fr[gi]
                    | (t[31] ? (FRAC_BITS'(1) << (FRAC_BITS - 1 - gi)) : '0);
                r_p[gi+1] <= r_p[gi];
            end
        end
    endgenerate

    // exponent: log times 1/gamma, rounded to Q.16
    logic signed [22:0] lg;
    logic signed [29:0] igs;
    logic signed [52:0] e;
    logic signed [52:0] er;
    logic [6:0]         pm;
    logic signed [20:0] r_k;
    logic [15:0]        r_f;

    assign pm = r_p[FRAC_BITS] - 7'd24;
    assign lg = $signed({pm, r_fr[FRAC_BITS]});
    assign igs = $signed({1'b0, i_cfg.inv_gamma});
    assign e = lg * igs;
    assign er = e + 53'sd32768;

    always_ff @(posedge i_clk) begin
        r_k <= er[52:32];
        r_f <= er[31:16];
    end

    // exp2 of the fraction, one root factor per stage
    logic [31:0]        r_v [0:FRAC_BITS];
    logic signed [20:0] r_xk [0:FRAC_BITS];
    logic [15:0]        r_xf [0:FRAC_BITS];

    assign r_v[0] = 32'd1 << 30;
    assign r_xk[0] = r_k;
    assign r_xf[0] = r_f;

    generate
        for (gi = 1; gi <= FRAC_BITS; gi++) begin : g_exp
            localparam logic [31:0] ROOT = root_at(gi);
            logic [63:0] pr;
            assign pr = 64'(r_v[gi-1]) * 64'(ROOT);
            always_ff @(posedge i_clk) begin
                r_v[gi] <= r_xf[gi-1][FRAC_BITS - gi] ? pr[61:30] : r_v[gi-1];
                r_xk[gi] <= r_xk[gi-1];
                r_xf[gi] <= r_xf[gi-1];
            end
        end
    endgenerate

    // scale back by c/m
    logic [63:0]        r_prod;
    logic signed [20:0] r_pk;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(r_v[FRAC_BITS]) * 64'(i_cfg.ratio_cm);
        r_pk <= r_xk[FRAC_BITS];
    end

    // shift by the integer exponent, round half up, saturate
    logic signed [21:0] shift;
    logic [5:0]         sh6;
    logic [64:0]        rnd;
    logic [W-1:0]       res;

    assign shift = 22'sd38 - 22'(r_pk);
    assign sh6 = shift[5:0];
    assign rnd = ({1'b0, r_prod} + (65'(1) << (sh6 - 6'd1))) >> sh6;

    always_comb begin
        if (r_ov[OVL-1]) begin
            res = r_ovv[OVL-1];
        end else if (r_pk >= 21'sd38) begin
            res = MASK;
        end else if (shift >= 22'sd64) begin
            res = '0;
        end else if (rnd > 65'(MASK)) begin
            res = MASK;
        end else begin
            res = rnd[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_y <= res;
    end

endmodule

### rtl/rgc_merge.sv
// Output stage: gathers the three lane words into one registered pixel
// with its strobe. Depends on rgc_pkg for the default channel width.
module rgc_merge #(
    parameter int CHANNEL_WIDTH = rgc_pkg::CHANNEL_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [CHANNEL_WIDTH-1:0] i_r,
    input  logic [CHANNEL_WIDTH-1:0] i_g,
    input  logic [CHANNEL_WIDTH-1:0] i_b,
    output logic                     o_done,
    output logic [CHANNEL_WIDTH-1:0] o_r,
    output logic [CHANNEL_WIDTH-1:0] o_g,
    output logic [CHANNEL_WIDTH-1:0] o_b
);
    logic                     r_done;
    logic [CHANNEL_WIDTH-1:0] r_r, r_g, r_b;

    // strobe for one cycle per pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
    end

    // capture the pixel when the lanes finish
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_r <= i_r;
            r_g <= i_g;
            r_b <= i_b;
        end
    end

    assign o_done = r_done;
    assign o_r = r_r;
    assign o_g = r_g;
    assign o_b = r_b;

endmodule

### tb/tb.sv
// Self-checking bench for rgb_gamma_clamp_core: APB register writes,
// pixels via start/busy, and checks of every o_done word against a model.
// Depends on rgc_pkg and the core RTL.
module tb;
    import rgc_pkg::*;

    localparam int W = CHANNEL_WIDTH_DEF;
    localparam int SETTLE = 60;

    typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_DRAIN} t_op;

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] green;
        logic [W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_op           op;
        logic [1:0]    reg_idx;
        logic [15:0]   value;
        t_pixel        px;
    } t_job;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready, start, busy, o_done;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic [W-1:0] i_red_in, i_green_in, i_blue_in;
    logic [W-1:0] o_red_out, o_green_out, o_blue_out;

    rgb_gamma_clamp_core #(.CHANNEL_WIDTH(W)) u_top (.*);

    // model state: registers and derived ratios
    logic [15:0] cur_clamp, cur_m, cur_c, cur_gamma;
    logic [63:0] ratio_up, ratio_down;
    longint      gamma_inv;
    logic [63:0] exp_roots[17];
    logic [15:0] cur_clamp_hint;

    t_job   jobs[$];
    t_pixel pending_px[$];
    int     errs, px_sent, px_checked, quiet, cfg_writes;
    bit     took, run_live;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] lo, hi, mid;
        lo = 0;
        hi = 64'h1_0000_0000;
        // largest r with r*r <= v
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void rederive();
        logic [63:0] m, c, g;
        m = (cur_m == 0) ? 64'd1 : 64'(cur_m);
        c = (cur_c == 0) ? 64'd1 : 64'(cur_c);
        g = (cur_gamma == 0) ? 64'd1 : 64'(cur_gamma);
        ratio_up = (m << 16) / c;
        ratio_down = (c << 16) / m;
        gamma_inv = longint'((64'd1 << 28) / g);
    endfunction

    // gamma curve of one channel
    function automatic logic [W-1:0] tone_map(input logic [W-1:0] x);
        logic [63:0] s, y, frac, v, prod;
        longint lg, e16, k, f;
        int p, sh;
        if (x >= cur_clamp) return cur_clamp;
        s = 64'(x) * ratio_up;
        if (s == 0) return '0;
        p = 63;
        while (!s[p]) p--;
        y = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
        frac = 0;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                frac[i] = 1'b1;
            end
        end
        lg = longint'(p - 24) * 65536 + longint'(frac);
        e16 = (lg * gamma_inv + 32768) >>> 16;
        k = e16 >>> 16;
        f = e16 - k * 65536;
        v = 64'd1 << 30;
        for (int i = 1; i <= 16; i++) begin
            if (f[16 - i]) v = (v * exp_roots[i]) >> 30;
        end
        prod = v * ratio_down;
        if (k >= 38) return '1;
        sh = int'(38 - k);
        if (sh >= 64) return '0;
        prod = (prod + (64'd1 << (sh - 1))) >> sh;
        return (prod > 64'hFFFF) ? '1 : prod[W-1:0];
    endfunction

    // accept pixels, apply register writes, check result words
    always @(posedge i_clk) begin
        t_pixel got, want;
        took = run_live && start && !busy;
        if (took) begin
            want.red = tone_map(i_red_in);
            want.green = tone_map(i_green_in);
            want.blue = tone_map(i_blue_in);
            pending_px.push_back(want);
        end
        if (run_live && psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_CLAMP:   cur_clamp = pwdata[15:0];
                REG_SCALE_M: cur_m = pwdata[15:0];
                REG_SCALE_C: cur_c = pwdata[15:0];
                REG_GAMMA:   cur_gamma = pwdata[15:0];
            endcase
            rederive();
        end
        if (run_live && o_done) begin
            got = '{o_red_out, o_green_out, o_blue_out};
            if (pending_px.size() == 0) begin
                $error("result word with nothing expected");
                errs++;
            end else begin
                want = pending_px.pop_front();
                px_checked++;
                if (got.red !== want.red) begin
                    $error("red_out: expected %0h, got %0h", want.red, got.red);
                    errs++;
                end
                if (got.green !== want.green) begin
                    $error("green_out: expected %0h, got %0h", want.green, got.green);
                    errs++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue_out: expected %0h, got %0h", want.blue, got.blue);
                    errs++;
                end
            end
        end
        quiet = (pending_px.size() == 0 && !took) ? quiet + 1 : 0;
    end

    // drive pixels and APB writes from the job queue
    always @(negedge i_clk) begin
        logic next_start;
        int   idle_pct;
        if (run_live) begin
            next_start = start && !took;
            idle_pct = (px_sent < 400) ? 11 : (px_sent < 800) ? 68 : 0;
            if (psel && !penable) begin
                penable <= 1'b1;
            end else if (psel) begin
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
            end else if (!next_start && jobs.size() != 0) begin
                case (jobs[0].op)
                    OP_PIXEL: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            i_red_in <= jobs[0].px.red;
                            i_green_in <= jobs[0].px.green;
                            i_blue_in <= jobs[0].px.blue;
                            next_start = 1'b1;
                            px_sent++;
                            void'(jobs.pop_front());
                        end
                    end
                    default: begin
                        // hold until the pipeline has drained
                        if (quiet >= SETTLE && !busy) begin
                            if (jobs[0].op == OP_WRITE) begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= ADDR_W'({jobs[0].reg_idx, 2'b00});
                                pwdata <= 32'(jobs[0].value);
                                cfg_writes++;
                            end
                            void'(jobs.pop_front());
                        end
                    end
                endcase
            end
            start <= next_start;
        end
    end

    function automatic void add_pixel(input logic [W-1:0] r, g, b);
        t_job j;
        j = '0;
        j.op = OP_PIXEL;
        j.px = '{r, g, b};
        jobs.push_back(j);
    endfunction

    function automatic void add_config(input logic [15:0] cl, m, c, g);
        t_job j;
        j = '0;
        j.op = OP_WRITE;
        j.reg_idx = REG_CLAMP;   j.value = cl; jobs.push_back(j);
        j.reg_idx = REG_SCALE_M; j.value = m;  jobs.push_back(j);
        j.reg_idx = REG_SCALE_C; j.value = c;  jobs.push_back(j);
        j.reg_idx = REG_GAMMA;   j.value = g;  jobs.push_back(j);
    endfunction

    function automatic logic [W-1:0] rand_chan();
        case ($urandom_range(3))
            0: return W'($urandom);
            1: return W'($urandom_range(cur_clamp_hint));
            2: return W'($urandom_range(15));
            default: return W'($urandom_range(1023));
        endcase
    endfunction

    initial begin
        t_job drain;
        drain = '0;
        drain.op = OP_DRAIN;
        {psel, penable, pwrite, start} = '0;
        paddr = '0;
        pwdata = '0;
        {i_red_in, i_green_in, i_blue_in} = '0;
        {errs, px_sent, px_checked, quiet, cfg_writes} = '0;
        took = 1'b0;
        run_live = 1'b0;
        cur_clamp = CLAMP_RST;
        cur_m = SCALE_RST;
        cur_c = SCALE_RST;
        cur_gamma = GAMMA_RST;
        rederive();
        exp_roots[0] = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) exp_roots[i] = int_sqrt(exp_roots[i - 1] << 30);
        cur_clamp_hint = CLAMP_RST;

        // directed: edges of the fields under the reset settings
        add_pixel(16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(16'h00FF, 16'h0100, 16'h0101);
        add_pixel(16'h0001, 16'h0002, 16'h0080);
        add_pixel(16'hAAAA, 16'h5555, 16'h00AA);
        add_pixel(16'h0055, 16'h0001, 16'h00FE);
        // clamp wide open, tiny and huge scaling, extreme gammas
        add_config(16'hFFFF, 16'd1, 16'hFFFF, 16'd1024);
        add_pixel(16'h0001, 16'hFFFE, 16'h8000);
        add_pixel(16'h00FF, 16'h0100, 16'h7FFF);
        add_config(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
        add_pixel(16'h0001, 16'hFFFE, 16'h8000);
        add_pixel(16'h0000, 16'h0010, 16'h1234);
        add_config(16'hFFFF, 16'hFFFF, 16'd1, 16'd1024);
        add_pixel(16'h0001, 16'h0100, 16'hFFFE);
        add_config(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        add_pixel(16'h0001, 16'h0002, 16'hFFFE);
        // zero registers act as one; clamp at zero passes nothing
        add_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'h0000, 16'h0001, 16'hFFFF);
        add_config(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'h0001, 16'h0100, 16'hFFFE);
        add_pixel(16'h0000, 16'h8000, 16'h00FF);

        // random phases with random settings
        for (int ph = 0; ph < 8; ph++) begin
            logic [15:0] cl;
            cl = (ph % 3 == 0) ? 16'hFFFF : 16'($urandom);
            cur_clamp_hint = (cl == 0) ? 16'd1 : cl;
            add_config(cl, 16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                       16'($urandom_range(65535, 1024)));
            for (int n = 0; n < 125; n++) begin
                add_pixel(rand_chan(), rand_chan(), rand_chan());
                if (n == 60) jobs.push_back(drain);
            end
        end
        add_config(CLAMP_RST, SCALE_RST, SCALE_RST, GAMMA_RST);
        for (int n = 0; n < 20; n++) add_pixel(rand_chan(), rand_chan(), rand_chan());

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        run_live = 1'b1;

        wait (jobs.size() == 0 && !start);
        wait (pending_px.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d pixels checked, %0d register writes, %0d errors",
                 px_checked, cfg_writes, errs);
        $display("settings included extreme scale, gamma, clamp and zero registers");
        if (errs == 0) begin
            $display("rgb_gamma_clamp_core regression: pass");
        end else begin
            $display("rgb_gamma_clamp_core regression: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(20 * 400000);
        $display("rgb_gamma_clamp_core regression: fail");
        $finish;
    end
endmodule
